[rtl/cfl_timestep_min_reduce_defines.svh]
// Assertion helpers for the CFL time-step reducer.
// Each macro takes a label, the clock, the active-low reset, a trigger and a check.
`ifndef CFL_TIMESTEP_MIN_REDUCE_DEFINES_SVH
`define CFL_TIMESTEP_MIN_REDUCE_DEFINES_SVH
`ifndef SYNTHESIS
`define CFLTSM_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("cfltsm: %m check failed");
`define CFLTSM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("cfltsm: %m check failed");
`else
`define CFLTSM_ASSERT_SAME(label, clk, rst_n, pre, post)
`define CFLTSM_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

[rtl/cfltsm_pkg.sv]
package cfltsm_pkg;

    localparam int DATA_W     = 32;
    localparam int PROD_W     = 64;
    localparam int DIV_W      = 33;
    localparam int REM_W      = 35;
    localparam int CFL_W      = 17;
    localparam int CFL_FRAC   = 16;
    localparam int PC_W       = 4;
    localparam int ITER_W     = 7;
    localparam int QUOT_STEPS = 64;
    localparam int ROOT_STEPS = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [DATA_W-1:0] ALL32 = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAS_GAMMA      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH_X   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH_Y   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COURANT_FACTOR = 2'd3;

    // microcode labels
    localparam logic [PC_W-1:0] PC_IDLE    = 4'd0;
    localparam logic [PC_W-1:0] PC_CS_SAT  = 4'd7;
    localparam logic [PC_W-1:0] PC_DX_INIT = 4'd8;

    typedef enum logic [3:0] {
        UOP_IDLE,
        UOP_MUL_PG,
        UOP_DIV_Q_INIT,
        UOP_DIV_STEP,
        UOP_SQRT_INIT,
        UOP_SQRT_STEP,
        UOP_CS_SQRT,
        UOP_CS_SAT,
        UOP_DX_INIT,
        UOP_DX_DONE,
        UOP_DY_INIT,
        UOP_DY_DONE,
        UOP_SCALE_MUL,
        UOP_EMIT
    } uop_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_JUMP,
        COND_WAIT_IN,
        COND_RHO_ZERO,
        COND_Q_BIG,
        COND_LOOP,
        COND_NOT_LAST,
        COND_OUT_WAIT
    } cond_t;

    typedef enum logic [1:0] {
        CNT_NONE,
        CNT_QUOT,
        CNT_ROOT,
        CNT_DT
    } cnt_t;

    typedef struct packed {
        uop_t            op;
        cond_t           cond;
        logic [PC_W-1:0] target;
        cnt_t            cnt;
    } ucode_t;

    typedef struct packed {
        logic in_fire;
        logic rho_zero;
        logic q_big;
        logic last;
        logic out_busy;
    } sts_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
        ucode_t w;
        unique case (addr)
            4'd0:  w = '{op: UOP_IDLE,       cond: COND_WAIT_IN,  target: PC_IDLE,    cnt: CNT_NONE};
            4'd1:  w = '{op: UOP_MUL_PG,     cond: COND_RHO_ZERO, target: PC_CS_SAT,  cnt: CNT_NONE};
            4'd2:  w = '{op: UOP_DIV_Q_INIT, cond: COND_NEXT,     target: PC_IDLE,    cnt: CNT_QUOT};
            4'd3:  w = '{op: UOP_DIV_STEP,   cond: COND_LOOP,     target: PC_IDLE,    cnt: CNT_NONE};
            4'd4:  w = '{op: UOP_SQRT_INIT,  cond: COND_Q_BIG,    target: PC_CS_SAT,  cnt: CNT_ROOT};
            4'd5:  w = '{op: UOP_SQRT_STEP,  cond: COND_LOOP,     target: PC_IDLE,    cnt: CNT_NONE};
            4'd6:  w = '{op: UOP_CS_SQRT,    cond: COND_JUMP,     target: PC_DX_INIT, cnt: CNT_NONE};
            4'd7:  w = '{op: UOP_CS_SAT,     cond: COND_NEXT,     target: PC_IDLE,    cnt: CNT_NONE};
            4'd8:  w = '{op: UOP_DX_INIT,    cond: COND_NEXT,     target: PC_IDLE,    cnt: CNT_DT};
            4'd9:  w = '{op: UOP_DIV_STEP,   cond: COND_LOOP,     target: PC_IDLE,    cnt: CNT_NONE};
            4'd10: w = '{op: UOP_DX_DONE,    cond: COND_NEXT,     target: PC_IDLE,    cnt: CNT_NONE};
            4'd11: w = '{op: UOP_DY_INIT,    cond: COND_NEXT,     target: PC_IDLE,    cnt: CNT_DT};
            4'd12: w = '{op: UOP_DIV_STEP,   cond: COND_LOOP,     target: PC_IDLE,    cnt: CNT_NONE};
            4'd13: w = '{op: UOP_DY_DONE,    cond: COND_NOT_LAST, target: PC_IDLE,    cnt: CNT_NONE};
            4'd14: w = '{op: UOP_SCALE_MUL,  cond: COND_NEXT,     target: PC_IDLE,    cnt: CNT_NONE};
            4'd15: w = '{op: UOP_EMIT,       cond: COND_OUT_WAIT, target: PC_IDLE,    cnt: CNT_NONE};
            default: w = '{op: UOP_IDLE,     cond: COND_JUMP,     target: PC_IDLE,    cnt: CNT_NONE};
        endcase
        return w;
    endfunction

endpackage

[rtl/cfltsm_seq.sv]
module cfltsm_seq #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfltsm_pkg::sts_t   sts,
    output cfltsm_pkg::ucode_t cw
);
    import cfltsm_pkg::*;

    localparam int DT_STEPS = DATA_W + FRAC_BITS;

    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [ITER_W-1:0] iter_reg, iter_next;

    assign cw = ucode_rom(pc_reg);

    // next step
    always_comb
    begin
        unique case (cw.cond)
            COND_NEXT:     pc_next = pc_reg + 1'b1;
            COND_JUMP:     pc_next = cw.target;
            COND_WAIT_IN:  pc_next = sts.in_fire ? pc_reg + 1'b1 : pc_reg;
            COND_RHO_ZERO: pc_next = sts.rho_zero ? cw.target : pc_reg + 1'b1;
            COND_Q_BIG:    pc_next = sts.q_big ? cw.target : pc_reg + 1'b1;
            COND_LOOP:     pc_next = (iter_reg == ITER_W'(1)) ? pc_reg + 1'b1 : pc_reg;
            COND_NOT_LAST: pc_next = sts.last ? pc_reg + 1'b1 : cw.target;
            COND_OUT_WAIT: pc_next = sts.out_busy ? pc_reg : cw.target;
            default:       pc_next = PC_IDLE;
        endcase
    end

    // iteration count for the loop steps
    always_comb
    begin
        unique case (cw.cnt)
            CNT_QUOT: iter_next = ITER_W'(QUOT_STEPS);
            CNT_ROOT: iter_next = ITER_W'(ROOT_STEPS);
            CNT_DT:   iter_next = ITER_W'(DT_STEPS);
            default:  iter_next = (cw.cond == COND_LOOP) ? iter_reg - 1'b1 : iter_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= PC_IDLE;
            iter_reg <= '0;
        end
        else
        begin
            pc_reg   <= pc_next;
            iter_reg <= iter_next;
        end
    end

endmodule

[rtl/cfl_timestep_min_reduce.sv]
// CFL time-step reducer for a 2-D Euler grid, Q16.16 fixed point by default.
// Input stream: one grid cell per transaction. s_axis_tdata carries pressure,
// density, velocity_x, velocity_y; s_axis_tlast marks the last cell of a sweep.
// Output stream: one transaction per sweep, on the last cell. m_axis_tdata is
// courant_factor times the smallest dx/(cs+|u|), dy/(cs+|v|) seen in the sweep,
// m_axis_tuser is set if any sound speed or cell quotient saturated during the sweep.
// Config port: cfg_we/cfg_index/cfg_wdata write gamma, dx, dy, Courant factor;
// write only while the block is idle.
// Timing: a microcoded sequencer drives one shared radix-2 divide/square-root
// datapath. A normal cell runs a 64-step quotient for gamma*p/rho, a 32-step
// root and two (32+FRAC_BITS)-step divisions before the next cell is accepted.
// Zero density skips the quotient and root steps; an oversized gamma*p/rho
// skips only the root. The result of a last cell is scaled by the Courant
// factor and registered into the output at the emit step.
// The result sits in an output register: the next cell is accepted while it
// waits, and the sequencer only stalls at its emit step if a new result is
// ready while the previous one has not been taken.
// Reset: config returns to gamma 1.4, dx = dy = 1.0, Courant 0.5; running
// minimum goes to all ones and the saturation flag clears.
`include "cfl_timestep_min_reduce_defines.svh"

module cfl_timestep_min_reduce #(
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // config write port
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    // cell stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // pressure, density, velocity_x, velocity_y
    input  logic         s_axis_tlast,  // last_cell
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,  // time_step
    output logic [0:0]   m_axis_tuser   // saturated
);
    import cfltsm_pkg::*;

    // configuration
    logic [DATA_W-1:0] gamma_reg, cwx_reg, cwy_reg;
    logic [CFL_W-1:0]  cfl_reg;

    // cell operands
    logic [DATA_W-1:0] p_reg, rho_reg, au_reg, av_reg;
    logic              last_reg;
    logic [DATA_W-1:0] p_next, rho_next, au_next, av_next;
    logic              last_next;

    // shared datapath
    logic [PROD_W-1:0] mul_reg, mul_next;
    logic [PROD_W-1:0] num_reg, num_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  div_reg, div_next;
    logic [DATA_W-1:0] root_reg, root_next;
    logic [DATA_W-1:0] cs_reg, cs_next;

    // sweep state
    logic [DATA_W-1:0] min_reg, min_next;
    logic              sat_reg, sat_next;

    // result register
    logic              ovalid_reg, ovalid_next;
    logic [DATA_W-1:0] otime_reg, otime_next;
    logic              osat_reg, osat_next;

    ucode_t seq_cw;
    sts_t   seq_sts;
    logic   in_fire;

    logic [DATA_W-1:0] vx_in, vy_in;
    logic [DATA_W-1:0] mul_a, mul_b;
    logic [PROD_W-1:0] mul_prod;
    logic [REM_W-1:0]  div_sh, div_ext, div_diff;
    logic              div_ge;
    logic [REM_W-1:0]  sq_sh, sq_trial, sq_diff;
    logic              sq_ge;
    logic              dt_sat;
    logic [DATA_W-1:0] dt_val;
    logic              rem_ok;

    cfltsm_seq #(
        .FRAC_BITS (FRAC_BITS)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (seq_sts),
        .cw    (seq_cw)
    );

    // handshakes: cells are taken only at the idle step
    assign s_axis_tready = (seq_cw.op == UOP_IDLE);
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = otime_reg;
    assign m_axis_tuser  = osat_reg;

    assign seq_sts.in_fire  = in_fire;
    assign seq_sts.rho_zero = (rho_reg == '0);
    // gamma*p/rho must leave room for the FRAC_BITS shift ahead of the root
    assign seq_sts.q_big    = (num_reg[PROD_W-1 -: FRAC_BITS] != '0);
    assign seq_sts.last     = last_reg;
    assign seq_sts.out_busy = ovalid_reg & ~m_axis_tready;

    // magnitudes; the most negative value maps to 2^31 exactly
    assign vx_in = s_axis_tdata[95:64];
    assign vy_in = s_axis_tdata[127:96];

    // the one multiplier: gamma*p per cell, min*Courant per sweep
    assign mul_a    = (seq_cw.op == UOP_SCALE_MUL) ? min_reg : p_reg;
    assign mul_b    = (seq_cw.op == UOP_SCALE_MUL) ? {{(DATA_W-CFL_W){1'b0}}, cfl_reg}
                                                   : gamma_reg;
    assign mul_prod = mul_a * mul_b;

    // restoring divide step: shift one numerator bit into the remainder
    assign div_sh   = {rem_reg[REM_W-2:0], num_reg[PROD_W-1]};
    assign div_ext  = {{(REM_W-DIV_W){1'b0}}, div_reg};
    assign div_ge   = (div_sh >= div_ext);
    assign div_diff = div_sh - div_ext;

    // digit-by-digit square root step: two radicand bits per step
    assign sq_sh    = {rem_reg[REM_W-3:0], num_reg[PROD_W-1 -: 2]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign sq_ge    = (sq_sh >= sq_trial);
    assign sq_diff  = sq_sh - sq_trial;

    // dx or dy quotient: zero denominator or more than 32 bits saturates
    assign dt_sat = (div_reg == '0) || (num_reg[PROD_W-1:DATA_W] != '0);
    assign dt_val = dt_sat ? ALL32 : num_reg[DATA_W-1:0];

    always_comb
    begin
        p_next      = p_reg;
        rho_next    = rho_reg;
        au_next     = au_reg;
        av_next     = av_reg;
        last_next   = last_reg;
        mul_next    = mul_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        root_next   = root_reg;
        cs_next     = cs_reg;
        min_next    = min_reg;
        sat_next    = sat_reg;
        otime_next  = otime_reg;
        osat_next   = osat_reg;
        ovalid_next = ovalid_reg & ~m_axis_tready;

        unique case (seq_cw.op)
            UOP_IDLE:
            begin
                if (in_fire)
                begin
                    p_next    = s_axis_tdata[31:0];
                    rho_next  = s_axis_tdata[63:32];
                    au_next   = vx_in[DATA_W-1] ? (~vx_in + 1'b1) : vx_in;
                    av_next   = vy_in[DATA_W-1] ? (~vy_in + 1'b1) : vy_in;
                    last_next = s_axis_tlast;
                end
            end
            UOP_MUL_PG:
            begin
                mul_next = mul_prod;
            end
            UOP_DIV_Q_INIT:
            begin
                num_next = mul_reg;
                rem_next = '0;
                div_next = {1'b0, rho_reg};
            end
            UOP_DIV_STEP:
            begin
                rem_next = div_ge ? div_diff : div_sh;
                num_next = {num_reg[PROD_W-2:0], div_ge};
            end
            UOP_SQRT_INIT:
            begin
                num_next  = num_reg << FRAC_BITS;
                rem_next  = '0;
                root_next = '0;
            end
            UOP_SQRT_STEP:
            begin
                rem_next  = sq_ge ? sq_diff : sq_sh;
                root_next = {root_reg[DATA_W-2:0], sq_ge};
                num_next  = {num_reg[PROD_W-3:0], 2'b00};
            end
            UOP_CS_SQRT:
            begin
                cs_next = root_reg;
            end
            UOP_CS_SAT:
            begin
                cs_next  = ALL32;
                sat_next = 1'b1;
            end
            UOP_DX_INIT:
            begin
                // width << FRAC_BITS, left-aligned in the numerator shifter
                num_next = {cwx_reg, {(PROD_W-DATA_W){1'b0}}};
                rem_next = '0;
                div_next = {1'b0, cs_reg} + {1'b0, au_reg};
            end
            UOP_DY_INIT:
            begin
                num_next = {cwy_reg, {(PROD_W-DATA_W){1'b0}}};
                rem_next = '0;
                div_next = {1'b0, cs_reg} + {1'b0, av_reg};
            end
            UOP_DX_DONE, UOP_DY_DONE:
            begin
                if (dt_val < min_reg)
                    min_next = dt_val;
                if (dt_sat)
                    sat_next = 1'b1;
            end
            UOP_SCALE_MUL:
            begin
                mul_next = mul_prod;
            end
            UOP_EMIT:
            begin
                if (!seq_sts.out_busy)
                begin
                    otime_next  = (mul_reg[PROD_W-1:CFL_FRAC+DATA_W] != '0)
                                ? ALL32 : mul_reg[CFL_FRAC +: DATA_W];
                    osat_next   = sat_reg;
                    ovalid_next = 1'b1;
                    min_next    = ALL32;
                    sat_next    = 1'b0;
                end
            end
            default:
            begin
                ovalid_next = ovalid_reg & ~m_axis_tready;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg  <= 32'd91750;
            cwx_reg    <= 32'd65536;
            cwy_reg    <= 32'd65536;
            cfl_reg    <= 17'd32768;
            min_reg    <= ALL32;
            sat_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            min_reg    <= min_next;
            sat_reg    <= sat_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_GAS_GAMMA:      gamma_reg <= cfg_wdata;
                    REG_CELL_WIDTH_X:   cwx_reg   <= cfg_wdata;
                    REG_CELL_WIDTH_Y:   cwy_reg   <= cfg_wdata;
                    REG_COURANT_FACTOR: cfl_reg   <= cfg_wdata[CFL_W-1:0];
                    default:            cfl_reg   <= cfl_reg;
                endcase
            end
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        rho_reg   <= rho_next;
        au_reg    <= au_next;
        av_reg    <= av_next;
        last_reg  <= last_next;
        mul_reg   <= mul_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        root_reg  <= root_next;
        cs_reg    <= cs_next;
        otime_reg <= otime_next;
        osat_reg  <= osat_next;
    end

    // remainder stays below a nonzero divisor through every divide step
    assign rem_ok = (rem_reg < div_ext);

    `CFLTSM_ASSERT_NEXT(a_leave_idle, clk, rst_n, in_fire, !s_axis_tready)
    `CFLTSM_ASSERT_SAME(a_out_from_emit, clk, rst_n, $rose(ovalid_reg), $past(seq_cw.op) == UOP_EMIT)
    `CFLTSM_ASSERT_SAME(a_div_rem, clk, rst_n, (seq_cw.op == UOP_DIV_STEP) && (div_reg != '0), rem_ok)

endmodule
